/* sv/dmx_channel_patch_lookup_core_assert.svh */
// Assertion macros used by the checker file
`ifndef DMX_CHANNEL_PATCH_LOOKUP_CORE_ASSERT_SVH
`define DMX_CHANNEL_PATCH_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define DCPL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcpl: assertion failed");

// Next-cycle implication, held off during reset
`define DCPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcpl: assertion failed");

`endif

/* sv/dcpl_pkg.sv */
`default_nettype none

package dcpl_pkg;

   // Universe store size, fixed by the 9-bit slot fields
   localparam int UNIVERSE_SIZE = 512;
   localparam int DMX_AW        = 9;

   // Request codes
   localparam logic [2:0] OP_WRITE_DESC  = 3'd0;
   localparam logic [2:0] OP_SET_COUNT   = 3'd1;
   localparam logic [2:0] OP_WRITE_BASE  = 3'd2;
   localparam logic [2:0] OP_WRITE_DMX   = 3'd3;
   localparam logic [2:0] OP_LOOKUP      = 3'd4;
   localparam logic [2:0] OP_DFLT_LOOKUP = 3'd5;

   // One stored channel descriptor
   typedef struct packed {
      logic [7:0] id;
      logic [2:0] sec;
      logic [7:0] span;
      logic [7:0] dflt;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   typedef struct packed {
      logic [2:0] req_type;
      logic [1:0] personality;
      logic [4:0] entry_index;
      logic [7:0] chan_id;
      logic [2:0] section;
      logic [7:0] span;
      logic [7:0] default_value;
      logic [5:0] entry_count;
      logic [8:0] section_base;
      logic [8:0] dmx_address;
      logic [7:0] dmx_data;
   } req_data_type;

   typedef struct packed {
      logic       found;
      logic [7:0] level;
      logic [8:0] block_address;
      logic [7:0] block_span;
      logic [7:0] default_level;
      logic       address_overflow;
   } rsp_data_type;

endpackage

`default_nettype wire

/* sv/dmx_channel_patch_lookup_core.sv */
// Loads (descriptor, count, base, byte) and the config write give no response.
// Lookup: the descriptor RAM walk, at one read per cycle, stops at the first entry
// whose id matches; ADDR then builds the block address, LEVEL reads its level and
// DONE loads the response. A default lookup hit or a miss goes straight to DONE.
// One request in work at a time. Reset (synchronous): count/base tables and active
// personality cleared, then a sweep zeroes the universe store with req_ready low.
`default_nettype none

module dmx_channel_patch_lookup_core #(
   parameter int MAX_ENTRIES   = 32,
   parameter int PERSONALITIES = 4,
   parameter int SECTIONS      = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire dcpl_pkg::req_data_type  req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dcpl_pkg::rsp_data_type       rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [1:0]              csr_wr_data
);

   localparam int DESC_DEPTH = PERSONALITIES * MAX_ENTRIES;
   localparam int DESC_AW    = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
   localparam int DW         = dcpl_pkg::DMX_AW;

   logic                  desc_wr_en;
   logic [DESC_AW-1:0]    desc_wr_addr;
   dcpl_pkg::desc_type    desc_wr_data;
   logic                  desc_rd_en;
   logic [DESC_AW-1:0]    desc_rd_addr;
   dcpl_pkg::desc_type    desc_rd_data;
   logic                  dmx_wr_en;
   logic [DW-1:0]         dmx_wr_addr;
   logic [7:0]            dmx_wr_data;
   logic                  dmx_rd_en;
   logic [DW-1:0]         dmx_rd_addr;
   logic [7:0]            dmx_rd_data;

   // Personality descriptors
   dcpl_ram #(
      .WIDTH (dcpl_pkg::DESC_W),
      .DEPTH (DESC_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_wr_en),
      .wr_addr (desc_wr_addr),
      .wr_data (desc_wr_data),
      .rd_en   (desc_rd_en),
      .rd_addr (desc_rd_addr),
      .rd_data (desc_rd_data)
   );

   // Universe store
   dcpl_ram #(
      .WIDTH (8),
      .DEPTH (dcpl_pkg::UNIVERSE_SIZE)
   ) u_dmx_ram (
      .clock   (clock),
      .wr_en   (dmx_wr_en),
      .wr_addr (dmx_wr_addr),
      .wr_data (dmx_wr_data),
      .rd_en   (dmx_rd_en),
      .rd_addr (dmx_rd_addr),
      .rd_data (dmx_rd_data)
   );

   dcpl_seq #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .PERSONALITIES (PERSONALITIES),
      .SECTIONS      (SECTIONS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .desc_wr_en   (desc_wr_en),
      .desc_wr_addr (desc_wr_addr),
      .desc_wr_data (desc_wr_data),
      .desc_rd_en   (desc_rd_en),
      .desc_rd_addr (desc_rd_addr),
      .desc_rd_data (desc_rd_data),
      .dmx_wr_en    (dmx_wr_en),
      .dmx_wr_addr  (dmx_wr_addr),
      .dmx_wr_data  (dmx_wr_data),
      .dmx_rd_en    (dmx_rd_en),
      .dmx_rd_addr  (dmx_rd_addr),
      .dmx_rd_data  (dmx_rd_data)
   );

endmodule

`default_nettype wire

/* sv/dcpl_ram.sv */
`default_nettype none

// Simple dual-port synchronous RAM, registered read
module dcpl_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 512,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/dcpl_seq.sv */
`default_nettype none

// Request sequencer: small tables, descriptor walk, address build, result register
module dcpl_seq #(
   parameter int  MAX_ENTRIES   = 32,
   parameter int  PERSONALITIES = 4,
   parameter int  SECTIONS      = 8,
   localparam int DESC_DEPTH    = PERSONALITIES * MAX_ENTRIES,
   localparam int DESC_AW       = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire dcpl_pkg::req_data_type      req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output dcpl_pkg::rsp_data_type           rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_wr_data,
   output logic                             desc_wr_en,
   output logic [DESC_AW-1:0]               desc_wr_addr,
   output dcpl_pkg::desc_type               desc_wr_data,
   output logic                             desc_rd_en,
   output logic [DESC_AW-1:0]               desc_rd_addr,
   input  wire dcpl_pkg::desc_type          desc_rd_data,
   output logic                             dmx_wr_en,
   output logic [dcpl_pkg::DMX_AW-1:0]      dmx_wr_addr,
   output logic [7:0]                       dmx_wr_data,
   output logic                             dmx_rd_en,
   output logic [dcpl_pkg::DMX_AW-1:0]      dmx_rd_addr,
   input  wire logic [7:0]                  dmx_rd_data
);

   localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
   localparam int P_W        = (PERSONALITIES > 1) ? $clog2(PERSONALITIES) : 1;
   localparam int S_W        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int OFF_W      = 8 + $clog2(MAX_ENTRIES);
   localparam int SUM_W      = ((OFF_W > dcpl_pkg::DMX_AW) ? OFF_W : dcpl_pkg::DMX_AW) + 1;
   localparam int DW         = dcpl_pkg::DMX_AW;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ADDR,
      ST_LEVEL,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [DW-1:0]          clr_ff;
   logic [1:0]             active_ff;
   logic [CNT_W-1:0]       count_ff [PERSONALITIES];
   logic [DW-1:0]          base_ff [SECTIONS];

   logic [7:0]             id_ff;
   logic [P_W-1:0]         pers_ff;
   logic                   dflt_only_ff;
   logic [CNT_W-1:0]       limit_ff;
   logic [CNT_W-1:0]       rd_idx_ff;
   logic                   pend_ff;
   logic [OFF_W-1:0]       acc_ff [SECTIONS];
   logic [S_W-1:0]         hit_sec_ff;
   logic [7:0]             hit_span_ff;
   logic [7:0]             hit_dflt_ff;
   logic [DW-1:0]          addr_ff;
   logic                   ovf_ff;
   dcpl_pkg::rsp_data_type res_ff;
   logic                   rsp_valid_ff;
   dcpl_pkg::rsp_data_type rsp_data_ff;

   logic                   accept;
   logic                   issue;
   logic                   desc_ok;
   logic [1:0]             lookup_pers;
   logic                   lookup_pers_ok;
   logic [SUM_W-1:0]       addr_sum;

   function automatic logic [DESC_AW-1:0] desc_addr(input logic [P_W-1:0] p,
                                                    input logic [IDX_W-1:0] i);
      desc_addr = DESC_AW'(p) * DESC_AW'(MAX_ENTRIES) + DESC_AW'(i);
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Descriptor load port
   assign desc_ok = (req_data.personality < PERSONALITIES)
                 && (req_data.entry_index < MAX_ENTRIES)
                 && (req_data.section < SECTIONS);
   assign desc_wr_en   = accept && (req_data.req_type == dcpl_pkg::OP_WRITE_DESC) && desc_ok;
   assign desc_wr_addr = desc_addr(P_W'(req_data.personality), IDX_W'(req_data.entry_index));
   always_comb begin
      desc_wr_data      = '0;
      desc_wr_data.id   = req_data.chan_id;
      desc_wr_data.sec  = req_data.section;
      desc_wr_data.span = req_data.span;
      desc_wr_data.dflt = req_data.default_value;
   end

   // Walk: one descriptor read per cycle while entries remain
   assign issue        = (state_ff == ST_SCAN) && (rd_idx_ff < limit_ff);
   assign desc_rd_en   = issue;
   assign desc_rd_addr = desc_addr(pers_ff, IDX_W'(rd_idx_ff));

   // Universe store: zero sweep after reset, byte loads, one level read
   always_comb begin
      dmx_wr_en   = 1'b0;
      dmx_wr_addr = req_data.dmx_address;
      dmx_wr_data = req_data.dmx_data;
      if (state_ff == ST_CLEAR) begin
         dmx_wr_en   = 1'b1;
         dmx_wr_addr = clr_ff;
         dmx_wr_data = '0;
      end else if (accept && (req_data.req_type == dcpl_pkg::OP_WRITE_DMX)
                   && (req_data.dmx_address < dcpl_pkg::UNIVERSE_SIZE)) begin
         dmx_wr_en = 1'b1;
      end
   end

   assign addr_sum    = SUM_W'(base_ff[hit_sec_ff]) + SUM_W'(acc_ff[hit_sec_ff]);
   assign dmx_rd_en   = (state_ff == ST_ADDR);
   assign dmx_rd_addr = addr_sum[DW-1:0];

   // Personality searched by the accepted lookup
   assign lookup_pers    = (req_data.req_type == dcpl_pkg::OP_LOOKUP) ? active_ff
                                                                      : req_data.personality;
   assign lookup_pers_ok = (lookup_pers < PERSONALITIES);

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         active_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < PERSONALITIES; k++) begin
            count_ff[k] <= '0;
         end
         for (int k = 0; k < SECTIONS; k++) begin
            base_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         // response register: loaded from DONE, cleared once taken
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == DW'(dcpl_pkg::UNIVERSE_SIZE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (accept) begin
                  case (req_data.req_type)
                     dcpl_pkg::OP_SET_COUNT: begin
                        if (req_data.personality < PERSONALITIES) begin
                           count_ff[P_W'(req_data.personality)] <=
                              (req_data.entry_count > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                                   : CNT_W'(req_data.entry_count);
                        end
                     end
                     dcpl_pkg::OP_WRITE_BASE: begin
                        if (req_data.section < SECTIONS) begin
                           base_ff[S_W'(req_data.section)] <= req_data.section_base;
                        end
                     end
                     dcpl_pkg::OP_LOOKUP, dcpl_pkg::OP_DFLT_LOOKUP: begin
                        id_ff        <= req_data.chan_id;
                        pers_ff      <= P_W'(lookup_pers);
                        dflt_only_ff <= (req_data.req_type == dcpl_pkg::OP_DFLT_LOOKUP);
                        limit_ff     <= lookup_pers_ok ? count_ff[P_W'(lookup_pers)] : '0;
                        rd_idx_ff    <= '0;
                        pend_ff      <= 1'b0;
                        for (int k = 0; k < SECTIONS; k++) begin
                           acc_ff[k] <= '0;
                        end
                        state_ff <= ST_SCAN;
                     end
                     default: begin
                        // descriptor and byte loads go straight to the memories
                     end
                  endcase
               end
            end

            ST_SCAN: begin
               if (issue) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
               end
               pend_ff <= issue && !(pend_ff && (desc_rd_data.id == id_ff));
               if (pend_ff && (desc_rd_data.id == id_ff)) begin
                  // first match wins; a read still in flight is dropped
                  hit_sec_ff  <= S_W'(desc_rd_data.sec);
                  hit_span_ff <= desc_rd_data.span;
                  hit_dflt_ff <= desc_rd_data.dflt;
                  if (dflt_only_ff) begin
                     res_ff   <= '{found: 1'b1, level: 8'd0, block_address: 9'd0,
                                   block_span: 8'd0, default_level: desc_rd_data.dflt,
                                   address_overflow: 1'b0};
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_ADDR;
                  end
               end else if (pend_ff) begin
                  // earlier entry: add its span to its section's offset
                  for (int k = 0; k < SECTIONS; k++) begin
                     if (desc_rd_data.sec == 3'(k)) begin
                        acc_ff[k] <= acc_ff[k] + OFF_W'(desc_rd_data.span);
                     end
                  end
               end else if (!issue) begin
                  res_ff   <= '0;
                  state_ff <= ST_DONE;
               end
            end

            ST_ADDR: begin
               addr_ff  <= addr_sum[DW-1:0];
               ovf_ff   <= |addr_sum[SUM_W-1:DW];
               pend_ff  <= 1'b0;
               state_ff <= ST_LEVEL;
            end

            ST_LEVEL: begin
               res_ff   <= '{found: 1'b1, level: dmx_rd_data, block_address: addr_ff,
                             block_span: hit_span_ff, default_level: hit_dflt_ff,
                             address_overflow: ovf_ff};
               state_ff <= ST_DONE;
            end

            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/dcpl_checker.sv */
`default_nettype none

`include "dmx_channel_patch_lookup_core_assert.svh"

// Port-level checks on the lookup core
module dcpl_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire dcpl_pkg::req_data_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire dcpl_pkg::rsp_data_type rsp_data
);

   // stalled response holds
   `DCPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a miss carries all-zero fields
   `DCPL_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_data.found, rsp_data.level == 8'd0 && rsp_data.block_address == 9'd0 && rsp_data.block_span == 8'd0 && rsp_data.default_level == 8'd0 && !rsp_data.address_overflow)

   // store sweep keeps requests out straight after reset
   `DCPL_ASSERT_IMP(a_sweep_busy, clock, reset, $fell(reset), !req_ready)

   // a lookup in work blocks the next request
   `DCPL_ASSERT_NEXT(a_lookup_busy, clock, reset, req_valid && req_ready && (req_data.req_type == dcpl_pkg::OP_LOOKUP || req_data.req_type == dcpl_pkg::OP_DFLT_LOOKUP), !req_ready)

endmodule

bind dmx_channel_patch_lookup_core dcpl_checker u_dcpl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
